### hdl/skh64_pkg.sv
package skh64_pkg;

  localparam int WORD_W = 64;
  localparam int HALF_W = 32;
  localparam int KEY_LEN_W = 16;
  localparam int BCNT_W = 4;
  localparam int LENGTH_BITS_DEF = 16;

  localparam logic [WORD_W-1:0] HP1 = 64'd11400714785074694791;
  localparam logic [WORD_W-1:0] HP2 = 64'd14029467366897019727;
  localparam logic [WORD_W-1:0] HP3 = 64'd1609587929392839161;
  localparam logic [WORD_W-1:0] HP5 = 64'd2870177450012600261;

  localparam int ROT_WORD = 31;
  localparam int ROT_BYTE = 11;
  localparam int AV_SH1 = 33;
  localparam int AV_SH2 = 29;
  localparam int AV_SH3 = 32;

  localparam logic [BCNT_W-1:0] FULL_COUNT = 4'd8;

  typedef struct packed {
    logic [WORD_W-1:0]    key_word;
    logic [BCNT_W-1:0]    byte_count;
    logic                 first_word;
    logic [KEY_LEN_W-1:0] key_length;
    logic                 last_word;
  } req_t;

  typedef struct packed {
    logic [WORD_W-1:0] hash_value;
    logic              length_error;
  } rsp_t;

  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
  } mul_cmd_t;

  function automatic logic [WORD_W-1:0] rotl64(input logic [WORD_W-1:0] v, input int r);
    rotl64 = (v << r) | (v >> (WORD_W - r));
  endfunction

endpackage

### hdl/skh64_mul.sv
module skh64_mul
  import skh64_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  mul_cmd_t          cmd,
  output logic              done,
  output logic [WORD_W-1:0] p
);

  logic [WORD_W-1:0] a;
  logic [WORD_W-1:0] b;
  logic [WORD_W-1:0] acc;
  logic              busy;
  logic [1:0]        step;
  logic [HALF_W-1:0] ma;
  logic [HALF_W-1:0] mb;
  logic [WORD_W-1:0] prod;

  always_comb begin
    ma   = (step == 2'd2) ? a[WORD_W-1:HALF_W] : a[HALF_W-1:0];
    mb   = (step == 2'd1) ? b[WORD_W-1:HALF_W] : b[HALF_W-1:0];
    prod = WORD_W'(ma) * WORD_W'(mb);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= 2'd0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        step <= 2'd0;
      end else if (busy) begin
        if (step == 2'd2) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        step <= step + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      a <= cmd.a;
      b <= cmd.b;
    end
    if (busy) begin
      if (step == 2'd0) begin
        acc <= prod;
      end else begin
        acc[WORD_W-1:HALF_W] <= acc[WORD_W-1:HALF_W] + prod[HALF_W-1:0];
      end
    end
  end

  assign p = acc;

  a_start_idle: assert property (@(posedge clk) disable iff (rst) cmd.start |-> !busy)
    else $error("multiply started while busy");
  a_done_lat: assert property (@(posedge clk) disable iff (rst) cmd.start |-> ##4 done)
    else $error("multiply result not ready after three steps");
  a_done_quiet: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done raised while still stepping");

endmodule

### hdl/string_key_hash64_unit.sv
// Streaming 64-bit string key hash.
// Request channel (req_valid/req_ready/req_data) carries one key word per
// request: eight key bytes little-endian, the valid byte count, first and
// last marks, and on the first word the total key length.
// Response channel (rsp_valid/rsp_ready/rsp_data) returns one hash and a
// length error flag for each request marked last; other requests give none.
// All 64-bit multiplies run on one shared 32x32 multiplier, three passes
// per product. A full word takes 2 multiplies; a partial word takes 2
// multiplies per valid byte. A last word adds the avalanche (2 multiplies)
// and a load into the response register.
// req_ready is high only while the sequencer is idle.
// The response register holds a finished hash while the receiver stalls;
// the next request is taken meanwhile, and a further result waits in the
// sequencer until the register frees.
// Synchronous reset clears the hash state, byte counters, error flag and the
// response valid flag.
module string_key_hash64_unit
  import skh64_pkg::*;
#(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req_data,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp_data
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_WORD1 = 8'b0000_0010,
    S_WORD2 = 8'b0000_0100,
    S_BYTE1 = 8'b0000_1000,
    S_BYTE2 = 8'b0001_0000,
    S_AVAL1 = 8'b0010_0000,
    S_AVAL2 = 8'b0100_0000,
    S_EMIT  = 8'b1000_0000
  } state_t;

  state_t                 state;
  state_t                 state_next;
  logic [WORD_W-1:0]      running_hash;
  logic [LENGTH_BITS-1:0] bytes_seen;
  logic [LENGTH_BITS-1:0] expected_length;
  logic                   framing_error;
  logic [WORD_W-1:0]      word;
  logic [2:0]             left;
  logic                   last;
  logic [WORD_W-1:0]      final_hash;

  mul_cmd_t               mul_cmd;
  logic                   mul_done;
  logic [WORD_W-1:0]      mul_p;

  logic                   accept;
  logic [LENGTH_BITS-1:0] klen;
  logic [BCNT_W-1:0]      cnt;
  logic [WORD_W-1:0]      h0;
  logic [LENGTH_BITS-1:0] seen_base;
  logic [LENGTH_BITS:0]   seen_sum;
  logic                   framing_next;
  logic                   rsp_load;

  skh64_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .cmd  (mul_cmd),
    .done (mul_done),
    .p    (mul_p)
  );

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign rsp_load  = (state == S_EMIT) && (!rsp_valid || rsp_ready);

  always_comb begin
    klen      = LENGTH_BITS'(req_data.key_length);
    cnt       = (req_data.byte_count > FULL_COUNT) ? FULL_COUNT : req_data.byte_count;
    h0        = req_data.first_word ? (HP5 + WORD_W'(klen)) : running_hash;
    seen_base = req_data.first_word ? '0 : bytes_seen;
    seen_sum  = {1'b0, seen_base} + (LENGTH_BITS + 1)'(cnt);
    framing_next = (framing_error && !req_data.first_word)
                 || (req_data.byte_count > FULL_COUNT)
                 || ((cnt != FULL_COUNT) && !req_data.last_word)
                 || seen_sum[LENGTH_BITS];
  end

  always_comb begin
    mul_cmd    = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (cnt == FULL_COUNT) begin
            mul_cmd    = '{1'b1, req_data.key_word, HP2};
            state_next = S_WORD1;
          end else if (cnt != '0) begin
            mul_cmd    = '{1'b1, WORD_W'(req_data.key_word[7:0]), HP5};
            state_next = S_BYTE1;
          end else if (req_data.last_word) begin
            mul_cmd    = '{1'b1, h0 ^ (h0 >> AV_SH1), HP2};
            state_next = S_AVAL1;
          end
        end
      end
      S_WORD1: begin
        if (mul_done) begin
          mul_cmd    = '{1'b1, rotl64(running_hash ^ mul_p, ROT_WORD), HP1};
          state_next = S_WORD2;
        end
      end
      S_WORD2: begin
        if (mul_done) begin
          if (last) begin
            mul_cmd    = '{1'b1, mul_p ^ (mul_p >> AV_SH1), HP2};
            state_next = S_AVAL1;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_BYTE1: begin
        if (mul_done) begin
          mul_cmd    = '{1'b1, rotl64(running_hash ^ mul_p, ROT_BYTE), HP1};
          state_next = S_BYTE2;
        end
      end
      S_BYTE2: begin
        if (mul_done) begin
          if (left != '0) begin
            mul_cmd    = '{1'b1, WORD_W'(word[7:0]), HP5};
            state_next = S_BYTE1;
          end else if (last) begin
            mul_cmd    = '{1'b1, mul_p ^ (mul_p >> AV_SH1), HP2};
            state_next = S_AVAL1;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_AVAL1: begin
        if (mul_done) begin
          mul_cmd    = '{1'b1, mul_p ^ (mul_p >> AV_SH2), HP3};
          state_next = S_AVAL2;
        end
      end
      S_AVAL2: begin
        if (mul_done) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (rsp_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      running_hash    <= '0;
      bytes_seen      <= '0;
      expected_length <= '0;
      framing_error   <= 1'b0;
      rsp_valid       <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        running_hash  <= h0;
        framing_error <= framing_next;
        bytes_seen    <= seen_sum[LENGTH_BITS] ? '1 : seen_sum[LENGTH_BITS-1:0];
        if (req_data.first_word) begin
          expected_length <= klen;
        end
      end
      if (mul_done && (state == S_WORD2 || state == S_BYTE2)) begin
        running_hash <= mul_p;
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      word <= req_data.key_word >> 8;
      left <= 3'(cnt - 4'd1);
      last <= req_data.last_word;
    end
    if (mul_done && state == S_BYTE2 && left != '0) begin
      word <= word >> 8;
      left <= left - 3'd1;
    end
    if (mul_done && state == S_AVAL2) begin
      final_hash <= mul_p ^ (mul_p >> AV_SH3);
    end
    if (rsp_load) begin
      rsp_data.hash_value   <= final_hash;
      rsp_data.length_error <= framing_error || (bytes_seen != expected_length);
    end
  end

  a_done_wait: assert property (@(posedge clk) disable iff (rst)
      mul_done |-> (state == S_WORD1 || state == S_WORD2 || state == S_BYTE1
                    || state == S_BYTE2 || state == S_AVAL1 || state == S_AVAL2))
    else $error("multiply finished outside a wait state");
  a_emit_load: assert property (@(posedge clk) disable iff (rst) rsp_load |=> rsp_valid)
    else $error("finished hash not presented");
  a_empty_frame: assert property (@(posedge clk) disable iff (rst)
      accept && (req_data.byte_count == '0) && !req_data.last_word
      |=> (state == S_IDLE) && framing_error)
    else $error("empty non-last word not flagged");
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
      (state == S_IDLE) |-> !mul_done)
    else $error("multiplier active while idle");

endmodule

### verif/tb.sv
module tb;
  import skh64_pkg::*;

  localparam logic [63:0] MUL_P1 = 64'd11400714785074694791;
  localparam logic [63:0] MUL_P2 = 64'd14029467366897019727;
  localparam logic [63:0] MUL_P3 = 64'd1609587929392839161;
  localparam logic [63:0] MUL_P5 = 64'd2870177450012600261;
  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_LEN = 300;
  localparam int RANDOM_WORDS = 2000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req_data = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp_data;

  logic [63:0] acc_hash = '0;
  logic [15:0] acc_bytes = '0;
  logic [15:0] acc_target = '0;
  logic acc_fault = 1'b0;
  rsp_t owed_hashes[$];

  int mismatches = 0;
  int words_sent = 0;
  int quiet_cycles = 0;
  bit idle_on = 1'b1;
  int hold_asks = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int stall_left = 0;

  string_key_hash64_unit dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req_data(req_data),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp_data(rsp_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int draw_gap();
    return idle_on ? $urandom_range(0, 13) : 0;
  endfunction

  function automatic req_t word_of(logic [63:0] key, logic [3:0] cnt, logic first,
                                   logic [15:0] len, logic last);
    req_t w;
    w.key_word = key;
    w.byte_count = cnt;
    w.first_word = first;
    w.key_length = len;
    w.last_word = last;
    return w;
  endfunction

  task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    mismatches++;
  endtask

  task automatic absorb_word(input req_t w);
    logic [63:0] h;
    logic [63:0] a;
    logic [3:0] n;
    logic [16:0] sum;
    rsp_t r;
    if (w.first_word) begin
      acc_hash = MUL_P5 + 64'(w.key_length);
      acc_bytes = '0;
      acc_target = w.key_length;
      acc_fault = 1'b0;
    end
    n = w.byte_count;
    if (n > 4'd8) begin
      n = 4'd8;
      acc_fault = 1'b1;
    end
    if (n < 4'd8 && !w.last_word) acc_fault = 1'b1;
    h = acc_hash;
    if (n == 4'd8) begin
      h = h ^ (w.key_word * MUL_P2);
      h = {h[32:0], h[63:33]};
      h = h * MUL_P1;
    end else begin
      for (int i = 0; i < int'(n); i++) begin
        h = h ^ (64'(w.key_word[8*i +: 8]) * MUL_P5);
        h = {h[52:0], h[63:53]};
        h = h * MUL_P1;
      end
    end
    acc_hash = h;
    sum = {1'b0, acc_bytes} + 17'(n);
    if (sum > 17'h0FFFF) begin
      acc_bytes = 16'hFFFF;
      acc_fault = 1'b1;
    end else begin
      acc_bytes = sum[15:0];
    end
    if (w.last_word) begin
      a = h;
      a = a ^ (a >> 33);
      a = a * MUL_P2;
      a = a ^ (a >> 29);
      a = a * MUL_P3;
      a = a ^ (a >> 32);
      r.hash_value = a;
      r.length_error = acc_fault || (acc_bytes != acc_target);
      owed_hashes.push_back(r);
    end
  endtask

  task automatic send_word(input req_t w);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data <= w;
    do @(posedge clk); while (!req_ready);
    absorb_word(w);
    words_sent++;
  endtask

  task automatic send_key(int len, logic [15:0] stated, bit with_first);
    int nfull;
    int rem;
    if (len == 0) begin
      send_word(word_of({$urandom, $urandom}, 4'd0, with_first, stated, 1'b1));
      return;
    end
    nfull = len / 8;
    rem = len % 8;
    for (int k = 0; k < nfull; k++)
      send_word(word_of({$urandom, $urandom}, 4'd8, with_first && k == 0, stated,
                        rem == 0 && k == nfull - 1));
    if (rem != 0)
      send_word(word_of({$urandom, $urandom}, 4'(rem), with_first && nfull == 0, stated,
                        1'b1));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (owed_hashes.size() == 0) begin
          flag_mismatch("unexpected result", rsp_data.hash_value, '0);
        end else begin
          if (rsp_data.hash_value !== owed_hashes[0].hash_value)
            flag_mismatch("hash_value", rsp_data.hash_value, owed_hashes[0].hash_value);
          if (rsp_data.length_error !== owed_hashes[0].length_error)
            flag_mismatch("length_error", 64'(rsp_data.length_error),
                          64'(owed_hashes[0].length_error));
          void'(owed_hashes.pop_front());
        end
        stall_left = draw_gap();
      end
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  task automatic test_corner_words();
    // no first word after reset, then carry on past a last word
    send_word(word_of('1, 4'd8, 1'b0, 16'hFFFF, 1'b1));
    send_word(word_of('0, 4'd0, 1'b0, 16'h0000, 1'b1));
    send_word(word_of('0, 4'd8, 1'b1, 16'd8, 1'b1));
    send_word(word_of('1, 4'd8, 1'b1, 16'hFFFF, 1'b1));
    send_word(word_of('1, 4'd0, 1'b1, 16'd0, 1'b1));
    send_word(word_of('0, 4'd0, 1'b1, 16'd0, 1'b0));
    send_word(word_of('1, 4'd0, 1'b0, 16'd0, 1'b1));
    send_word(word_of('1, 4'd9, 1'b1, 16'd16, 1'b0));
    send_word(word_of('1, 4'd15, 1'b0, 16'd16, 1'b1));
    send_word(word_of({$urandom, $urandom}, 4'd3, 1'b1, 16'd11, 1'b0));
    send_word(word_of({$urandom, $urandom}, 4'd8, 1'b0, 16'd11, 1'b1));
    send_word(word_of({$urandom, $urandom}, 4'd8, 1'b1, 16'd8, 1'b1));
    send_word(word_of({$urandom, $urandom}, 4'd4, 1'b0, 16'd8, 1'b1));
    for (int c = 1; c < 8; c++)
      send_word(word_of({$urandom, $urandom}, 4'(c), 1'b1, 16'(c), 1'b1));
  endtask

  task automatic test_random_keys();
    int start;
    int pick;
    int len;
    start = words_sent;
    while (words_sent - start < RANDOM_WORDS) begin
      idle_on = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 19);
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 24);
      if (pick < 14) begin
        send_key(len, 16'(len), 1'b1);
      end else if (pick < 16) begin
        send_key(len, 16'($urandom), 1'b1);
      end else if (pick < 17) begin
        send_key(len, 16'($urandom), 1'b0);
      end else if (pick < 19) begin
        send_word(word_of({$urandom, $urandom}, 4'($urandom), 1'($urandom),
                          16'($urandom), 1'($urandom)));
      end else begin
        send_word(word_of({$urandom, $urandom}, 4'($urandom_range(0, 7)), 1'b1,
                          16'(len + 4), 1'b0));
        send_key(len, 16'(len), 1'b0);
      end
    end
    idle_on = 1'b1;
  endtask

  task automatic test_output_stall();
    idle_on = 1'b0;
    hold_asks++;
    for (int k = 0; k < 12; k++) send_key($urandom_range(0, 16), 16'($urandom_range(0, 16)), 1'b1);
    idle_on = 1'b1;
  endtask

  task automatic test_length_limits();
    idle_on = 1'b0;
    // stated lengths at the top of the range, then a long key with its true length
    send_key(8, 16'hFFFF, 1'b1);
    send_key(300, 16'hFFF8, 1'b1);
    send_key(296, 16'd296, 1'b1);
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_corner_words();
    test_output_stall();
    test_random_keys();
    test_length_limits();
    req_valid <= 1'b0;
    while (owed_hashes.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end

endmodule
